// ===== hw/rtl/bcd_pkg.sv =====
package bcd_pkg;

    localparam int MAX_IMAGE_DIM = 4096;
    localparam int DIM_W         = $clog2(MAX_IMAGE_DIM) + 1;
    localparam int COORD_W       = $clog2(MAX_IMAGE_DIM);
    localparam int BLK_W         = COORD_W - 2;
    localparam int ADDR_W        = 4;

    localparam logic [1:0] REG_FORMAT = 2'd0;
    localparam logic [1:0] REG_WIDTH  = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;

    typedef struct packed {
        logic             fmt_bc3;
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
    } cfg_t;

    typedef struct packed {
        logic [15:0]      ea;
        logic [15:0]      eb;
        logic [31:0]      csel;
        logic [7:0]       a0;
        logic [7:0]       a1;
        logic [47:0]      asel;
        logic [BLK_W-1:0] blk_col;
        logic [BLK_W-1:0] blk_row;
        logic [1:0]       last_col;
        logic [1:0]       last_row;
    } blk_t;

    typedef struct packed {
        logic [3:0][23:0] rgb;
        logic [7:0][7:0]  alpha;
        logic             four;
    } pal_t;

    typedef struct packed {
        logic       valid;
        logic [1:0] tcol;
        logic [1:0] trow;
        logic       last;
    } emit_t;

    function automatic logic [23:0] widen565(input logic [15:0] c);
        logic [4:0] r;
        logic [5:0] g;
        logic [4:0] b;
        r = c[15:11];
        g = c[10:5];
        b = c[4:0];
        return {r, r[4:2], g, g[5:4], b, b[4:2]};
    endfunction

    // reciprocal multiply, exact for v < 2048
    function automatic logic [7:0] div3(input logic [9:0] v);
        logic [20:0] p;
        p = {11'd0, v} * 21'd683;
        return p[18:11];
    endfunction

    // exact for v < 16384
    function automatic logic [7:0] div5(input logic [10:0] v);
        logic [22:0] p;
        p = {12'd0, v} * 23'd3277;
        return p[21:14];
    endfunction

    // exact for v < 5461
    function automatic logic [7:0] div7(input logic [10:0] v);
        logic [22:0] p;
        p = {12'd0, v} * 23'd2341;
        return p[21:14];
    endfunction

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        if (v == '0)
        begin
            return DIM_W'(1);
        end
        else if (v > DIM_W'(MAX_IMAGE_DIM))
        begin
            return DIM_W'(MAX_IMAGE_DIM);
        end
        return v;
    endfunction

endpackage

// ===== hw/rtl/bcd_cfg_regs.sv =====
module bcd_cfg_regs
    import bcd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output cfg_t              cfg
);

    logic             fmt_reg;
    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;
    logic [1:0]       reg_idx;
    logic             wr_en;

    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg    <= 1'b0;
            width_reg  <= DIM_W'(MAX_IMAGE_DIM);
            height_reg <= DIM_W'(MAX_IMAGE_DIM);
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_FORMAT: fmt_reg    <= pwdata[0];
                REG_WIDTH:  width_reg  <= pwdata[DIM_W-1:0];
                REG_HEIGHT: height_reg <= pwdata[DIM_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_FORMAT: prdata = {31'd0, fmt_reg};
            REG_WIDTH:  prdata = {{(32-DIM_W){1'b0}}, width_reg};
            REG_HEIGHT: prdata = {{(32-DIM_W){1'b0}}, height_reg};
            default:    prdata = 32'd0;
        endcase
    end

    assign cfg.fmt_bc3 = fmt_reg;
    assign cfg.width   = clamp_dim(width_reg);
    assign cfg.height  = clamp_dim(height_reg);

endmodule

// ===== hw/rtl/bcd_palette.sv =====
module bcd_palette
    import bcd_pkg::*;
(
    input  blk_t blk,
    output pal_t pal
);

    logic [23:0] c0;
    logic [23:0] c1;
    logic        four;

    assign c0   = widen565(blk.ea);
    assign c1   = widen565(blk.eb);
    assign four = blk.ea > blk.eb;

    always_comb
    begin
        logic [7:0]  a;
        logic [7:0]  b;
        logic [8:0]  avg;
        logic [10:0] s;
        pal.rgb[0] = c0;
        pal.rgb[1] = c1;
        pal.rgb[2] = '0;
        pal.rgb[3] = '0;
        pal.four   = four;
        for (int ch = 0; ch < 3; ch++)
        begin
            a   = c0[8*ch +: 8];
            b   = c1[8*ch +: 8];
            avg = {1'b0, a} + {1'b0, b};
            if (four)
            begin
                pal.rgb[2][8*ch +: 8] = div3({1'b0, a, 1'b0} + {2'b00, b});
                pal.rgb[3][8*ch +: 8] = div3({2'b00, a} + {1'b0, b, 1'b0});
            end
            else
            begin
                pal.rgb[2][8*ch +: 8] = avg[8:1];
                pal.rgb[3][8*ch +: 8] = 8'h00;
            end
        end

        // alpha palette, 8-entry or 6-entry mode
        pal.alpha    = '0;
        pal.alpha[0] = blk.a0;
        pal.alpha[1] = blk.a1;
        if (blk.a0 > blk.a1)
        begin
            for (int k = 1; k <= 6; k++)
            begin
                s = 11'(7 - k) * {3'd0, blk.a0} + 11'(k) * {3'd0, blk.a1};
                pal.alpha[k+1] = div7(s);
            end
        end
        else
        begin
            for (int k = 1; k <= 4; k++)
            begin
                s = 11'(5 - k) * {3'd0, blk.a0} + 11'(k) * {3'd0, blk.a1};
                pal.alpha[k+1] = div5(s);
            end
            pal.alpha[6] = 8'h00;
            pal.alpha[7] = 8'hFF;
        end
    end

endmodule

// ===== hw/rtl/bcd_block_seq.sv =====
module bcd_block_seq
    import bcd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [15:0] endpoint_a,
    input  logic [15:0] endpoint_b,
    input  logic [31:0] color_selectors,
    input  logic [7:0]  alpha_end_a,
    input  logic [7:0]  alpha_end_b,
    input  logic [47:0] alpha_selectors,
    input  logic        load_ok,
    output blk_t        blk,
    output emit_t       emit
);

    logic             blk_valid_reg, blk_valid_next;
    logic [BLK_W-1:0] pos_col_reg, pos_col_next;
    logic [BLK_W-1:0] pos_row_reg, pos_row_next;
    logic [1:0]       tcol_reg, tcol_next;
    logic [1:0]       trow_reg, trow_next;
    blk_t             blk_reg;

    logic             accept;
    logic             is_last;
    logic             do_emit;
    logic [DIM_W-1:0] base_x;
    logic [DIM_W-1:0] base_y;
    logic [DIM_W-1:0] span_x;
    logic [DIM_W-1:0] span_y;
    logic             hit_x;
    logic             hit_y;
    logic [DIM_W-1:0] w_round;
    logic [DIM_W-1:0] h_round;
    logic [BLK_W:0]   col_inc;
    logic [BLK_W:0]   row_inc;

    assign is_last  = (tcol_reg == blk_reg.last_col) && (trow_reg == blk_reg.last_row);
    assign do_emit  = blk_valid_reg && load_ok;
    assign in_stall = blk_valid_reg && !(load_ok && is_last);
    assign accept   = in_valid && !in_stall;

    // visible span of the block at the current position
    assign base_x = {1'b0, pos_col_reg, 2'b00};
    assign base_y = {1'b0, pos_row_reg, 2'b00};
    assign span_x = cfg.width - base_x;
    assign span_y = cfg.height - base_y;
    assign hit_x  = cfg.width > base_x;
    assign hit_y  = cfg.height > base_y;

    // blocks per row and block rows, rounded up
    assign w_round = cfg.width + DIM_W'(3);
    assign h_round = cfg.height + DIM_W'(3);
    assign col_inc = {1'b0, pos_col_reg} + (BLK_W+1)'(1);
    assign row_inc = {1'b0, pos_row_reg} + (BLK_W+1)'(1);

    always_comb
    begin
        blk_valid_next = blk_valid_reg;
        tcol_next      = tcol_reg;
        trow_next      = trow_reg;
        pos_col_next   = pos_col_reg;
        pos_row_next   = pos_row_reg;
        if (do_emit)
        begin
            if (is_last)
            begin
                blk_valid_next = 1'b0;
            end
            else if (tcol_reg == blk_reg.last_col)
            begin
                tcol_next = 2'd0;
                trow_next = trow_reg + 2'd1;
            end
            else
            begin
                tcol_next = tcol_reg + 2'd1;
            end
        end
        if (accept)
        begin
            blk_valid_next = hit_x && hit_y;
            tcol_next      = 2'd0;
            trow_next      = 2'd0;
            if (col_inc >= w_round[DIM_W-1:2])
            begin
                pos_col_next = '0;
                if (row_inc >= h_round[DIM_W-1:2])
                begin
                    pos_row_next = '0;
                end
                else
                begin
                    pos_row_next = row_inc[BLK_W-1:0];
                end
            end
            else
            begin
                pos_col_next = col_inc[BLK_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blk_valid_reg <= 1'b0;
            tcol_reg      <= 2'd0;
            trow_reg      <= 2'd0;
            pos_col_reg   <= '0;
            pos_row_reg   <= '0;
        end
        else
        begin
            blk_valid_reg <= blk_valid_next;
            tcol_reg      <= tcol_next;
            trow_reg      <= trow_next;
            pos_col_reg   <= pos_col_next;
            pos_row_reg   <= pos_row_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            blk_reg.ea       <= endpoint_a;
            blk_reg.eb       <= endpoint_b;
            blk_reg.csel     <= color_selectors;
            blk_reg.a0       <= alpha_end_a;
            blk_reg.a1       <= alpha_end_b;
            blk_reg.asel     <= alpha_selectors;
            blk_reg.blk_col  <= pos_col_reg;
            blk_reg.blk_row  <= pos_row_reg;
            blk_reg.last_col <= (span_x >= DIM_W'(4)) ? 2'd3 : 2'(span_x - DIM_W'(1));
            blk_reg.last_row <= (span_y >= DIM_W'(4)) ? 2'd3 : 2'(span_y - DIM_W'(1));
        end
    end

    assign blk        = blk_reg;
    assign emit.valid = do_emit;
    assign emit.tcol  = tcol_reg;
    assign emit.trow  = trow_reg;
    assign emit.last  = is_last;

endmodule

// ===== hw/rtl/bc1_bc3_texture_block_decoder.sv =====
// BC1 / BC3 texture block decoder
// input channel: one compressed 4x4 block per transaction (in_valid / in_stall),
// blocks in raster block order across the configured image
// output channel: one texel per transaction (out_valid / out_stall) with its
// image column and row, ARGB color and a block_last flag on the final texel
// emitted for the block; texels outside the image are not emitted
// a block is held in a block register and its texels leave one per cycle,
// while the output is not stalled, through an output register; a full block
// yields sixteen texels, fewer at clipped edges
// the next block is taken in the same cycle that the last texel moves out,
// so blocks stream back to back with no bubble
// a fully clipped block is taken and produces nothing
// stalling the output freezes the output register and the texel walk; the
// input then stalls once the current block is held
// reset clears the block position to the image origin, empties both stages
// and sets BC1 format with a 4096 x 4096 image; the format and size registers
// sit on the APB port, to be written by the user only while idle (unenforced)
module bc1_bc3_texture_block_decoder
    import bcd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [15:0]        endpoint_a,
    input  logic [15:0]        endpoint_b,
    input  logic [31:0]        color_selectors,
    input  logic [7:0]         alpha_end_a,
    input  logic [7:0]         alpha_end_b,
    input  logic [47:0]        alpha_selectors,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [COORD_W-1:0] pixel_col,
    output logic [COORD_W-1:0] pixel_row,
    output logic [31:0]        argb,
    output logic               block_last
);

    cfg_t  cfg;
    blk_t  blk;
    pal_t  pal;
    emit_t emit;

    logic               out_valid_reg;
    logic [COORD_W-1:0] pixel_col_reg;
    logic [COORD_W-1:0] pixel_row_reg;
    logic [31:0]        argb_reg;
    logic               block_last_reg;
    logic               load_ok;
    logic [3:0]         tidx;
    logic [1:0]         ci;
    logic [2:0]         ai;
    logic [5:0]         a_pos;
    logic [7:0]         alpha_sel;
    logic [31:0]        argb_next;

    bcd_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    bcd_block_seq u_block_seq (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .endpoint_a      (endpoint_a),
        .endpoint_b      (endpoint_b),
        .color_selectors (color_selectors),
        .alpha_end_a     (alpha_end_a),
        .alpha_end_b     (alpha_end_b),
        .alpha_selectors (alpha_selectors),
        .load_ok         (load_ok),
        .blk             (blk),
        .emit            (emit)
    );

    bcd_palette u_palette (
        .blk (blk),
        .pal (pal)
    );

    assign load_ok = !out_valid_reg || !out_stall;

    // texel color select
    assign tidx  = {emit.trow, emit.tcol};
    assign ci    = blk.csel[{tidx, 1'b0} +: 2];
    assign a_pos = {2'b00, tidx} + {1'b0, tidx, 1'b0};
    assign ai    = blk.asel[a_pos +: 3];

    always_comb
    begin
        if (cfg.fmt_bc3)
        begin
            alpha_sel = pal.alpha[ai];
        end
        else if (ci == 2'd3 && !pal.four)
        begin
            alpha_sel = 8'h00;
        end
        else
        begin
            alpha_sel = 8'hFF;
        end
        argb_next = {alpha_sel, pal.rgb[ci]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_ok)
        begin
            out_valid_reg <= emit.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit.valid)
        begin
            pixel_col_reg  <= {blk.blk_col, emit.tcol};
            pixel_row_reg  <= {blk.blk_row, emit.trow};
            argb_reg       <= argb_next;
            block_last_reg <= emit.last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign pixel_col  = pixel_col_reg;
    assign pixel_row  = pixel_row_reg;
    assign argb       = argb_reg;
    assign block_last = block_last_reg;

endmodule

// ===== sim/tb_bc1_bc3_texture_block_decoder.sv =====
`timescale 1ns / 1ps

module tb_bc1_bc3_texture_block_decoder;

    import bcd_pkg::*;

    localparam logic [1:0] REG_UNUSED    = 2'd3;
    localparam int         CYCLE_LIMIT   = 400000;
    localparam int         SETTLE_CYCLES = 20;
    localparam int         RANDOM_BLOCKS = 236;

    typedef struct {
        logic [15:0] ea;
        logic [15:0] eb;
        logic [31:0] csel;
        logic [7:0]  a0;
        logic [7:0]  a1;
        logic [47:0] asel;
    } s3tc_block_t;

    typedef struct {
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic [31:0]        argb;
        logic               last;
    } texel_t;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [ADDR_W-1:0]  paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    logic               in_valid;
    logic               in_stall;
    logic [15:0]        endpoint_a;
    logic [15:0]        endpoint_b;
    logic [31:0]        color_selectors;
    logic [7:0]         alpha_end_a;
    logic [7:0]         alpha_end_b;
    logic [47:0]        alpha_selectors;
    logic               out_valid;
    logic               out_stall;
    logic [COORD_W-1:0] pixel_col;
    logic [COORD_W-1:0] pixel_row;
    logic [31:0]        argb;
    logic               block_last;

    // shadow of the register file and the block position
    logic               img_fmt_bc3;
    logic [DIM_W-1:0]   img_width;
    logic [DIM_W-1:0]   img_height;
    int unsigned        pos_col;
    int unsigned        pos_row;

    texel_t             texel_queue [$];
    texel_t             want_tx;
    int                 mismatches;
    int                 gap_pct;
    int                 cycle_count;

    bc1_bc3_texture_block_decoder dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .endpoint_a      (endpoint_a),
        .endpoint_b      (endpoint_b),
        .color_selectors (color_selectors),
        .alpha_end_a     (alpha_end_a),
        .alpha_end_b     (alpha_end_b),
        .alpha_selectors (alpha_selectors),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .pixel_col       (pixel_col),
        .pixel_row       (pixel_row),
        .argb            (argb),
        .block_last      (block_last)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic logic [23:0] expand_rgb565(input logic [15:0] c);
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        r = {c[15:11], c[15:13]};
        g = {c[10:5], c[10:9]};
        b = {c[4:0], c[4:2]};
        return {r, g, b};
    endfunction

    function automatic logic [23:0] mix_rgb(input logic [23:0] p, input int wp,
                                            input logic [23:0] q, input int wq);
        logic [23:0] r;
        for (int s = 0; s < 24; s += 8)
        begin
            r[s +: 8] = 8'((int'(p[s +: 8]) * wp + int'(q[s +: 8]) * wq) / (wp + wq));
        end
        return r;
    endfunction

    function automatic int unsigned clip_dim(input logic [DIM_W-1:0] v);
        if (v == 0)
        begin
            return 1;
        end
        if (int'(v) > MAX_IMAGE_DIM)
        begin
            return MAX_IMAGE_DIM;
        end
        return 32'(v);
    endfunction

    task automatic predict_block_texels(input s3tc_block_t b);
        int unsigned w;
        int unsigned h;
        int unsigned bx;
        int unsigned by;
        int unsigned px;
        int unsigned py;
        int          ci;
        int          ai;
        int          av0;
        int          av1;
        int          last_t;
        logic        four;
        logic [23:0] rgb_pal [4];
        logic [7:0]  a_pal [8];
        logic [7:0]  alpha;
        texel_t      tx;
        w    = clip_dim(img_width);
        h    = clip_dim(img_height);
        bx   = (w + 3) / 4;
        by   = (h + 3) / 4;
        four = b.ea > b.eb;
        rgb_pal[0] = expand_rgb565(b.ea);
        rgb_pal[1] = expand_rgb565(b.eb);
        if (four)
        begin
            rgb_pal[2] = mix_rgb(rgb_pal[0], 2, rgb_pal[1], 1);
            rgb_pal[3] = mix_rgb(rgb_pal[0], 1, rgb_pal[1], 2);
        end
        else
        begin
            rgb_pal[2] = mix_rgb(rgb_pal[0], 1, rgb_pal[1], 1);
            rgb_pal[3] = '0;
        end
        av0 = int'(b.a0);
        av1 = int'(b.a1);
        a_pal[0] = b.a0;
        a_pal[1] = b.a1;
        if (av0 > av1)
        begin
            for (int k = 1; k <= 6; k++)
            begin
                a_pal[k + 1] = 8'(((7 - k) * av0 + k * av1) / 7);
            end
        end
        else
        begin
            for (int k = 1; k <= 4; k++)
            begin
                a_pal[k + 1] = 8'(((5 - k) * av0 + k * av1) / 5);
            end
            a_pal[6] = 8'd0;
            a_pal[7] = 8'd255;
        end
        last_t = -1;
        for (int t = 0; t < 16; t++)
        begin
            px = pos_col * 4 + (t % 4);
            py = pos_row * 4 + (t / 4);
            if (px < w && py < h)
            begin
                last_t = t;
            end
        end
        for (int t = 0; t < 16; t++)
        begin
            px = pos_col * 4 + (t % 4);
            py = pos_row * 4 + (t / 4);
            if (px < w && py < h)
            begin
                ci = int'((b.csel >> (2 * t)) & 32'd3);
                ai = int'((b.asel >> (3 * t)) & 48'd7);
                if (img_fmt_bc3)
                begin
                    alpha = a_pal[ai];
                end
                else if (!four && ci == 3)
                begin
                    alpha = 8'h00;
                end
                else
                begin
                    alpha = 8'hFF;
                end
                tx.col  = COORD_W'(px);
                tx.row  = COORD_W'(py);
                tx.argb = {alpha, rgb_pal[ci]};
                tx.last = (t == last_t);
                texel_queue.push_back(tx);
            end
        end
        if (pos_col + 1 >= bx)
        begin
            pos_col = 0;
            if (pos_row + 1 >= by)
            begin
                pos_row = 0;
            end
            else
            begin
                pos_row++;
            end
        end
        else
        begin
            pos_col++;
        end
    endtask

    task automatic send_block(input s3tc_block_t b);
        while (gap_pct != 0 && $urandom_range(99) < gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid        <= 1'b1;
        endpoint_a      <= b.ea;
        endpoint_b      <= b.eb;
        color_selectors <= b.csel;
        alpha_end_a     <= b.a0;
        alpha_end_b     <= b.a1;
        alpha_selectors <= b.asel;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        predict_block_texels(b);
    endtask

    task automatic send_fixed(input logic [15:0] ea, input logic [15:0] eb,
                              input logic [31:0] csel, input logic [7:0] a0,
                              input logic [7:0] a1, input logic [47:0] asel);
        s3tc_block_t b;
        b.ea   = ea;
        b.eb   = eb;
        b.csel = csel;
        b.a0   = a0;
        b.a1   = a1;
        b.asel = asel;
        send_block(b);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (texel_queue.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic reg_write(input logic [1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        case (idx)
            REG_FORMAT: img_fmt_bc3 = value[0];
            REG_WIDTH:  img_width   = value[DIM_W-1:0];
            REG_HEIGHT: img_height  = value[DIM_W-1:0];
            default:    ;
        endcase
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_image(input logic fmt, input logic [31:0] w, input logic [31:0] h);
        reg_write(REG_FORMAT, {$urandom} & ~32'd1 | 32'(fmt));
        reg_write(REG_WIDTH, w);
        reg_write(REG_HEIGHT, h);
    endtask

    task automatic test_reset_image();
        send_fixed(16'hFFFF, 16'h0000, $urandom, 8'hFF, 8'h00, 48'h0);
        send_fixed(16'h0000, 16'hFFFF, 32'hFFFF_FFFF, 8'h00, 8'hFF, 48'hFFFF_FFFF_FFFF);
        send_fixed(16'h1234, 16'h1234, 32'h0000_0000, 8'($urandom), 8'($urandom), 48'h0);
        settle();
    endtask

    task automatic test_bc1_palette();
        // position is past the new row end: that block is dropped and wraps
        set_image(1'b0, 32'd8, 32'd8);
        send_fixed(16'hF800, 16'h001F, 32'hE4E4_E4E4, 8'h00, 8'h00, 48'h0);
        send_fixed(16'h07E0, 16'hF81F, 32'hE4E4_E4E4, 8'h00, 8'h00, 48'h0);
        send_fixed(16'h0000, 16'h0000, 32'h1B1B_1B1B, 8'h00, 8'h00, 48'h0);
        send_fixed(16'hFFFF, 16'hFFFF, 32'hE4E4_E4E4, 8'h00, 8'h00, 48'h0);
        send_fixed(16'hFFFF, 16'hFFFE, 32'h1B1B_1B1B, 8'h00, 8'h00, 48'h0);
        settle();
    endtask

    task automatic test_bc3_alpha();
        set_image(1'b1, 32'd8, 32'd8);
        send_fixed(16'hFFFF, 16'h0000, 32'hE4E4_E4E4, 8'hFF, 8'h00, 48'o7654321076543210);
        send_fixed(16'h0000, 16'hFFFF, 32'hE4E4_E4E4, 8'h00, 8'hFF, 48'o0123456701234567);
        send_fixed(16'hA5A5, 16'h5A5A, $urandom, 8'h80, 8'h80, 48'o7654321076543210);
        send_fixed(16'($urandom), 16'($urandom), $urandom, 8'hC3, 8'h17, 48'hFFFF_FFFF_FFFF);
        send_fixed(16'($urandom), 16'($urandom), $urandom, 8'h17, 8'hC3, 48'h0);
        settle();
    endtask

    task automatic test_edge_clipping();
        set_image(1'b1, 32'd5, 32'd7);
        repeat (5) send_fixed(16'($urandom), 16'($urandom), $urandom, 8'($urandom),
                              8'($urandom), 48'o7654321076543210);
        settle();
        set_image(1'b0, 32'd1, 32'd1);
        repeat (2) send_fixed(16'($urandom), 16'($urandom), $urandom, 8'h00, 8'h00, 48'h0);
        settle();
        set_image(1'b1, 32'd0, 32'd0);
        repeat (2) send_fixed(16'($urandom), 16'($urandom), $urandom, 8'($urandom),
                              8'($urandom), 48'h0);
        settle();
        reg_write(REG_UNUSED, $urandom);
        set_image(1'b0, 32'h1FFF, 32'd4097);
        repeat (2) send_fixed(16'($urandom), 16'($urandom), $urandom, 8'h00, 8'h00, 48'h0);
        settle();
    endtask

    function automatic logic [31:0] pick_dim();
        if ($urandom_range(7) == 0)
        begin
            return {$urandom} & 32'h1FFF;
        end
        return $urandom_range(1, 20);
    endfunction

    task automatic test_random_streams();
        s3tc_block_t b;
        int          sent;
        int          phase;
        int          len;
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_BLOCKS)
        begin
            set_image(1'($urandom_range(1)), pick_dim(), pick_dim());
            gap_pct = (phase == 1) ? 0 : 9;
            len     = (phase == 1) ? 60 : $urandom_range(10, 40);
            if (len > RANDOM_BLOCKS - sent)
            begin
                len = RANDOM_BLOCKS - sent;
            end
            repeat (len)
            begin
                b.ea   = 16'($urandom);
                b.eb   = ($urandom_range(7) == 0) ? b.ea : 16'($urandom);
                b.csel = $urandom;
                b.a0   = 8'($urandom);
                b.a1   = ($urandom_range(7) == 0) ? b.a0 : 8'($urandom);
                b.asel = 48'({$urandom, $urandom});
                send_block(b);
                sent++;
            end
            settle();
            gap_pct = 9;
            phase++;
        end
    endtask

    always @(posedge clk)
    begin
        out_stall <= (gap_pct != 0) && ($urandom_range(99) < gap_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (texel_queue.size() == 0)
            begin
                $display("%0t unexpected texel col %0d row %0d argb %h",
                         $time, pixel_col, pixel_row, argb);
                mismatches++;
            end
            else
            begin
                want_tx = texel_queue.pop_front();
                if (pixel_col !== want_tx.col)
                begin
                    $display("%0t pixel_col expected %0d got %0d", $time, want_tx.col, pixel_col);
                    mismatches++;
                end
                if (pixel_row !== want_tx.row)
                begin
                    $display("%0t pixel_row expected %0d got %0d", $time, want_tx.row, pixel_row);
                    mismatches++;
                end
                if (argb !== want_tx.argb)
                begin
                    $display("%0t argb expected %h got %h", $time, want_tx.argb, argb);
                    mismatches++;
                end
                if (block_last !== want_tx.last)
                begin
                    $display("%0t block_last expected %b got %b", $time, want_tx.last, block_last);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("bc1_bc3_texture_block_decoder verification failed");
        $finish;
    end

    initial
    begin
        mismatches      = 0;
        gap_pct         = 9;
        img_fmt_bc3     = 1'b0;
        img_width       = DIM_W'(MAX_IMAGE_DIM);
        img_height      = DIM_W'(MAX_IMAGE_DIM);
        pos_col         = 0;
        pos_row         = 0;
        rst_n           <= 1'b0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;
        in_valid        <= 1'b0;
        endpoint_a      <= '0;
        endpoint_b      <= '0;
        color_selectors <= '0;
        alpha_end_a     <= '0;
        alpha_end_b     <= '0;
        alpha_selectors <= '0;
        out_stall       <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_image();
        test_bc1_palette();
        test_bc3_alpha();
        test_edge_clipping();
        test_random_streams();
        settle();

        if (mismatches == 0)
        begin
            $display("bc1_bc3_texture_block_decoder verification clean");
        end
        else
        begin
            $display("bc1_bc3_texture_block_decoder verification failed");
        end
        $finish;
    end

endmodule
